>>> design/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS + 1;
   // Dividend magnitude with fraction extension plus half-divisor rounding term.
   localparam int NUM_BITS  = PROD_BITS + FRAC_BITS + 2;
   localparam int DEN_BITS  = 2 * WORD_BITS + 2;
   localparam int QUO_BITS  = NUM_BITS;
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                  op;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_re;
      logic signed [WORD_BITS-1:0] res_im;
      logic                        overflow;
      logic                        div_zero;
   } rsp_type;

   // Classified item passed from the front part to the back part.
   typedef struct packed {
      logic [1:0]                  op;
      logic                        div_zero;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } task_type;

   // Saturate a signed magnitude to the signed word range.
   function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                   input logic [QUO_BITS-1:0] mag);
      logic [QUO_BITS-1:0] lim;
      logic [WORD_BITS-1:0] w;
      logic ov;
      lim = QUO_BITS'(1) << (WORD_BITS - 1);
      ov = 1'b0;
      if (neg) begin
         if (mag > lim) begin
            ov = 1'b1;
            w = lim[WORD_BITS-1:0];
         end else begin
            w = WORD_BITS'(0) - mag[WORD_BITS-1:0];
         end
      end else begin
         if (mag > lim - QUO_BITS'(1)) begin
            ov = 1'b1;
            w = lim[WORD_BITS-1:0] - WORD_BITS'(1);
         end else begin
            w = mag[WORD_BITS-1:0];
         end
      end
      return {ov, w};
   endfunction
endpackage

>>> design/cau_front.sv
`timescale 1ns / 1ps
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cau_pkg::req_type  req_data,
   output logic              task_valid,
   input  logic              task_ready,
   output cau_pkg::task_type task_data
);
   import cau_pkg::*;

   task_type mem [Q_DEPTH];
   logic [Q_AW:0] wr_ff, wr_in, rd_ff, rd_in;
   task_type item;
   logic do_push, do_pop;

   always_comb begin
      item.op       = req_data.op;
      item.a_re     = req_data.a_re;
      item.a_im     = req_data.a_im;
      item.b_re     = req_data.b_re;
      item.b_im     = req_data.b_im;
      item.div_zero = (op_type'(req_data.op) == OP_DIV) &&
                      (req_data.b_re == '0) && (req_data.b_im == '0);
   end

   assign full       = (wr_ff[Q_AW] != rd_ff[Q_AW]) && (wr_ff[Q_AW-1:0] == rd_ff[Q_AW-1:0]);
   assign task_valid = (wr_ff != rd_ff);
   assign task_data  = mem[rd_ff[Q_AW-1:0]];
   assign do_push    = push && !full;
   assign do_pop     = task_valid && task_ready;
   assign wr_in      = wr_ff + (Q_AW+1)'(do_push);
   assign rd_in      = rd_ff + (Q_AW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff[Q_AW-1:0]] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end
endmodule

>>> design/cau_divider.sv
`timescale 1ns / 1ps
module cau_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          idle,
   input  logic [cau_pkg::NUM_BITS-1:0]  num_re,
   input  logic [cau_pkg::NUM_BITS-1:0]  num_im,
   input  logic [cau_pkg::DEN_BITS-1:0]  den,
   output logic                          done,
   output logic [cau_pkg::QUO_BITS-1:0]  quo_re,
   output logic [cau_pkg::QUO_BITS-1:0]  quo_im
);
   import cau_pkg::*;

   localparam int CW = $clog2(NUM_BITS + 1);

   // Two restoring dividers share one counter, one quotient bit each per cycle.
   logic [NUM_BITS-1:0] nre_ff, nim_ff;
   logic [DEN_BITS:0]   rre_ff, rim_ff, d_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff, done_ff;
   logic [DEN_BITS:0]   tre, tim;

   assign idle   = !busy_ff;
   assign done   = done_ff;
   assign quo_re = nre_ff;
   assign quo_im = nim_ff;
   assign tre    = {rre_ff[DEN_BITS-1:0], nre_ff[NUM_BITS-1]};
   assign tim    = {rim_ff[DEN_BITS-1:0], nim_ff[NUM_BITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_BITS);
            nre_ff  <= num_re;
            nim_ff  <= num_im;
            rre_ff  <= '0;
            rim_ff  <= '0;
            d_ff    <= {den, 1'b0};
         end else if (busy_ff) begin
            if (tre >= d_ff) begin
               rre_ff <= tre - d_ff;
               nre_ff <= {nre_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rre_ff <= tre;
               nre_ff <= {nre_ff[NUM_BITS-2:0], 1'b0};
            end
            if (tim >= d_ff) begin
               rim_ff <= tim - d_ff;
               nim_ff <= {nim_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rim_ff <= tim;
               nim_ff <= {nim_ff[NUM_BITS-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

>>> design/cau_back.sv
`timescale 1ns / 1ps
module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              task_valid,
   output logic              task_ready,
   input  cau_pkg::task_type task_data,
   output logic              empty,
   input  logic              pop,
   output cau_pkg::rsp_type  rsp_data
);
   import cau_pkg::*;

   localparam int W2 = 2 * WORD_BITS;

   // Stage 1: products.  Stage 2: sums and divider set-up.  Stage 3: result.
   logic              v1_ff, v2_ff, v3_ff;
   task_type          t1_ff;
   logic signed [W2-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [1:0]        op2_ff;
   logic              dz2_ff;
   logic signed [PROD_BITS-1:0] s_re_ff, s_im_ff, l_re_ff, l_im_ff;
   rsp_type           r3_ff;
   logic              hold_ff;
   logic              stall, div_wait, adv3;
   logic              div_idle, div_done;
   logic [QUO_BITS-1:0] q_re, q_im;
   logic              nre_ff, nim_ff;
   logic signed [PROD_BITS-1:0] s_re, s_im;
   logic signed [W2-1:0] sq_re, sq_im;
   logic [NUM_BITS-1:0] n_re, n_im;
   logic [DEN_BITS-1:0] den;
   logic [WORD_BITS:0] sre, sim;
   logic [QUO_BITS-1:0] m_re, m_im;
   logic div_start;

   function automatic logic [QUO_BITS-1:0] mag_of(input logic signed [PROD_BITS-1:0] v);
      logic [PROD_BITS-1:0] u;
      u = v[PROD_BITS-1] ? (PROD_BITS'(0) - v) : v;
      return QUO_BITS'(u);
   endfunction

   // A divide with a nonzero divisor waits in stage 2 until its quotients are ready.
   assign div_wait = v2_ff && (op_type'(op2_ff) == OP_DIV) && !dz2_ff && !hold_ff;
   assign adv3     = v2_ff && !div_wait && (!v3_ff || pop);
   assign stall    = v2_ff && !adv3;
   assign task_ready = !(v1_ff && stall);
   assign empty    = !v3_ff;
   assign rsp_data = r3_ff;

   assign sq_re = t1_ff.b_re * t1_ff.b_re;
   assign sq_im = t1_ff.b_im * t1_ff.b_im;

   always_comb begin
      s_re = PROD_BITS'(p_rr_ff) + PROD_BITS'(p_ii_ff);
      s_im = PROD_BITS'(p_ir_ff) - PROD_BITS'(p_ri_ff);
      case (op_type'(t1_ff.op))
         OP_ADD: begin
            s_re = PROD_BITS'(t1_ff.a_re) + PROD_BITS'(t1_ff.b_re);
            s_im = PROD_BITS'(t1_ff.a_im) + PROD_BITS'(t1_ff.b_im);
         end
         OP_SUB: begin
            s_re = PROD_BITS'(t1_ff.a_re) - PROD_BITS'(t1_ff.b_re);
            s_im = PROD_BITS'(t1_ff.a_im) - PROD_BITS'(t1_ff.b_im);
         end
         OP_MUL: begin
            s_re = PROD_BITS'(p_rr_ff) - PROD_BITS'(p_ii_ff);
            s_im = PROD_BITS'(p_ri_ff) + PROD_BITS'(p_ir_ff);
         end
         default: ;
      endcase
   end

   // Divider operands: 2|num|*2^F + den over 2*den gives round-half-away.
   assign m_re = mag_of(s_re_ff);
   assign m_im = mag_of(s_im_ff);
   assign den  = DEN_BITS'(l_re_ff) + DEN_BITS'(l_im_ff);
   assign n_re = (NUM_BITS'(m_re) << (FRAC_BITS + 1)) + NUM_BITS'(den);
   assign n_im = (NUM_BITS'(m_im) << (FRAC_BITS + 1)) + NUM_BITS'(den);
   assign div_start = div_wait && div_idle && !div_done && !hold_ff;

   cau_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .idle   (div_idle),
      .num_re (n_re),
      .num_im (n_im),
      .den    (den),
      .done   (div_done),
      .quo_re (q_re),
      .quo_im (q_im)
   );

   always_comb begin
      case (op_type'(op2_ff))
         OP_ADD, OP_SUB: begin
            sre = sat_word(s_re_ff[PROD_BITS-1], mag_of(s_re_ff));
            sim = sat_word(s_im_ff[PROD_BITS-1], mag_of(s_im_ff));
         end
         OP_MUL: begin
            sre = sat_word(s_re_ff[PROD_BITS-1],
                     (mag_of(s_re_ff) + (QUO_BITS'(1) << FRAC_BITS >> 1)) >> FRAC_BITS);
            sim = sat_word(s_im_ff[PROD_BITS-1],
                     (mag_of(s_im_ff) + (QUO_BITS'(1) << FRAC_BITS >> 1)) >> FRAC_BITS);
         end
         default: begin
            sre = sat_word(nre_ff, q_re);
            sim = sat_word(nim_ff, q_im);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (!(v1_ff && stall)) begin
         t1_ff   <= task_data;
         p_rr_ff <= task_data.a_re * task_data.b_re;
         p_ii_ff <= task_data.a_im * task_data.b_im;
         p_ri_ff <= task_data.a_re * task_data.b_im;
         p_ir_ff <= task_data.a_im * task_data.b_re;
      end
      if (!stall) begin
         op2_ff  <= t1_ff.op;
         dz2_ff  <= t1_ff.div_zero;
         s_re_ff <= s_re;
         s_im_ff <= s_im;
         l_re_ff <= PROD_BITS'(sq_re);
         l_im_ff <= PROD_BITS'(sq_im);
      end
      if (div_start) begin
         nre_ff <= s_re_ff[PROD_BITS-1];
         nim_ff <= s_im_ff[PROD_BITS-1];
      end
      if (adv3) begin
         if (dz2_ff) begin
            r3_ff <= '{res_re: '0, res_im: '0, overflow: 1'b0, div_zero: 1'b1};
         end else begin
            r3_ff <= '{res_re: sre[WORD_BITS-1:0], res_im: sim[WORD_BITS-1:0],
                       overflow: sre[WORD_BITS] | sim[WORD_BITS], div_zero: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         if (!(v1_ff && stall)) begin
            v1_ff <= task_valid;
         end
         if (!stall) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= 1'b1;
         end else if (pop) begin
            v3_ff <= 1'b0;
         end
         // Quotients stay in the divider until the result register takes them.
         if (div_done) begin
            hold_ff <= 1'b1;
         end else if (adv3) begin
            hold_ff <= 1'b0;
         end
      end
   end
endmodule

>>> design/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Add, subtract and multiply: one item per cycle while results are popped and
// no divide holds the pipeline. Divide: the shared restoring divider produces
// one quotient bit per cycle for both parts; a divide finishes before the next
// one starts, and items behind a divide wait for it.
// A 4-entry queue separates intake from the arithmetic pipeline.
// Reset is synchronous and empties the queue and the pipeline.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cau_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic     task_valid, task_ready;
   task_type task_data;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .task_valid (task_valid),
      .task_ready (task_ready),
      .task_data  (task_data)
   );

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_ready (task_ready),
      .task_data  (task_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.div_zero |-> rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("divide by zero result not zero");
   a_dz_noov: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_data.div_zero && rsp_data.overflow))
      else $error("both flags set");
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not empty after reset");
endmodule
